FILE: hdl/touch_gesture_classifier_macros.svh
// Assertion helpers for the RTL; sampled on clk, off while rst_n is low.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define TGC_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TGC_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tgc_pkg.sv
package tgc_pkg;

    localparam int SLOT_LIMIT_DEF = 15;
    localparam int COORD_BITS_DEF = 12;

    localparam int CFG_W   = 13;
    localparam int VEL_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 32;

    typedef enum logic [2:0] {
        REG_JITTER,
        REG_WIDTH,
        REG_HEIGHT,
        REG_VELOCITY,
        REG_LONG,
        REG_TWOTAP
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] jitter;
        logic [CFG_W-1:0] view_w;
        logic [CFG_W-1:0] view_h;
        logic [VEL_W-1:0] min_speed;
        logic [CFG_W-1:0] long_len;
        logic [CFG_W-1:0] pair_gap;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        jitter:    CFG_W'(30),
        view_w:    CFG_W'(1404),
        view_h:    CFG_W'(1872),
        min_speed: VEL_W'(20),
        long_len:  CFG_W'(800),
        pair_gap:  CFG_W'(500)
    };

    localparam logic [1:0] ACT_DOWN = 2'd1;
    localparam logic [1:0] ACT_UP   = 2'd2;

    localparam logic MODE_ONE = 1'b0;
    localparam logic MODE_TWO = 1'b1;

    localparam logic [3:0] GEST_TAP_LEFT    = 4'd0;
    localparam logic [3:0] GEST_TAP_RIGHT   = 4'd1;
    localparam logic [3:0] GEST_SWIPE_RIGHT = 4'd2;
    localparam logic [3:0] GEST_SWIPE_LEFT  = 4'd3;
    localparam logic [3:0] GEST_UP          = 4'd4;
    localparam logic [3:0] GEST_UP_LONG     = 4'd5;
    localparam logic [3:0] GEST_DOWN        = 4'd6;
    localparam logic [3:0] GEST_DOWN_LONG   = 4'd7;
    localparam logic [3:0] GEST_TWO_TAP     = 4'd8;

    localparam int TAP_MARGIN  = 100;
    localparam int TOC_SIZE    = 150;
    localparam int VEL_SCALE   = 10;
    // floor(w/3) == (w*10923) >> 15 for every w below 2^15
    localparam int THIRD_RECIP = 10923;
    localparam int THIRD_SHIFT = 15;

endpackage

FILE: hdl/tgc_queue.sv
module tgc_queue
    import tgc_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] dout,
    output logic             valid
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem [DEPTH];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == 2'(DEPTH));
    assign valid = (count_reg != 2'd0);
    assign dout  = mem[rptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/tgc_front.sv
module tgc_front
    import tgc_pkg::*;
#(
    parameter int SLOT_LIMIT = SLOT_LIMIT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int PTW = 2 * COORD_BITS + STAMP_W,
    localparam int JW  = 1 + 2 * COORD_BITS + 4 * PTW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [1:0]            action,
    input  logic [3:0]            slot,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [STAMP_W-1:0]    stamp,
    input  logic                  job_full,
    output logic                  job_push,
    output logic [JW-1:0]         job_data
);

    localparam int DEPTH = (SLOT_LIMIT + 1 > 16) ? 16 : SLOT_LIMIT + 1;
    localparam int IW    = $clog2(DEPTH);

    logic [PTW-1:0]    start_reg [DEPTH];
    logic [PTW-1:0]    end_reg   [DEPTH];
    logic signed [7:0] contact_reg, contact_next;
    logic [7:0]        stroke_reg, stroke_next;

    logic              accept;
    logic              slot_ok;
    logic              do_down;
    logic              do_up;
    logic [IW-1:0]     idx;
    logic [PTW-1:0]    new_pt;
    logic [PTW-1:0]    end0;
    logic [PTW-1:0]    end1;
    logic [PTW-1:0]    second;
    logic signed [7:0] base;
    logic signed [7:0] dec;

    assign accept  = push && !job_full;
    assign slot_ok = (int'(slot) <= SLOT_LIMIT);
    assign do_down = accept && slot_ok && (action == ACT_DOWN);
    assign do_up   = accept && slot_ok && (action == ACT_UP);
    assign idx     = slot[IW-1:0];
    assign new_pt  = {pos_x, pos_y, stamp};

    // end points as they stand after this word's write
    assign end0   = (do_up && idx == IW'(0)) ? new_pt : end_reg[0];
    assign end1   = (do_up && idx == IW'(1)) ? new_pt : end_reg[1];
    assign second = (stroke_reg == 8'd2) ? start_reg[1] : end0;

    assign job_data = {((stroke_reg == 8'd2) ? MODE_TWO : MODE_ONE),
                       pos_x, pos_y, start_reg[0], second, end0, end1};

    always_comb
    begin
        contact_next = contact_reg;
        stroke_next  = stroke_reg;
        job_push     = 1'b0;
        base         = contact_reg[7] ? 8'sd0 : contact_reg;
        dec          = (contact_reg != -8'sd128) ? contact_reg - 8'sd1 : contact_reg;
        if (do_down)
        begin
            contact_next = (base != 8'sd127) ? base + 8'sd1 : base;
            stroke_next  = (stroke_reg != 8'd255) ? stroke_reg + 8'd1 : stroke_reg;
        end
        else if (do_up)
        begin
            contact_next = dec;
            if (dec == 8'sd0)
            begin
                stroke_next = 8'd0;
                job_push    = (stroke_reg == 8'd1) || (stroke_reg == 8'd2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contact_reg <= 8'sd0;
            stroke_reg  <= 8'd0;
            for (int i = 0; i < DEPTH; i++)
            begin
                start_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end
        else
        begin
            contact_reg <= contact_next;
            stroke_reg  <= stroke_next;
            if (do_down)
            begin
                start_reg[idx] <= new_pt;
            end
            if (do_up)
            begin
                end_reg[idx] <= new_pt;
            end
        end
    end

endmodule

FILE: hdl/tgc_back.sv
module tgc_back
    import tgc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int PTW = 2 * COORD_BITS + STAMP_W,
    localparam int JW  = 1 + 2 * COORD_BITS + 4 * PTW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          job_valid,
    input  logic [JW-1:0] job_data,
    output logic          job_pop,
    input  logic          pop,
    output logic          empty,
    output logic [3:0]    gesture
);

    `include "touch_gesture_classifier_macros.svh"

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int SQW = 2 * DW;
    localparam int RTW = C + 1;
    localparam int RMW = C + 3;
    localparam int NIT = C + 1;
    localparam int NW  = C + 5;
    localparam int CW  = $clog2(NW + 1);
    localparam int XW  = (RTW > CFG_W) ? RTW : CFG_W;
    localparam int VW  = (NW > VEL_W) ? NW : VEL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MULX,
        S_MULY,
        S_SQRT,
        S_DIV,
        S_DECIDE
    } state_t;

    state_t                st_reg;
    logic [JW-1:0]         job_reg;
    logic                  pass_reg;
    logic signed [DW-1:0]  dx_reg;
    logic signed [DW-1:0]  dy_reg;
    logic [STAMP_W-1:0]    dt_reg;
    logic [SQW-1:0]        sq_reg;
    logic [SQW-1:0]        rad_reg;
    logic [RTW-1:0]        root_reg;
    logic [RMW-1:0]        rem_reg;
    logic [CW-1:0]         cnt_reg;
    logic [RTW-1:0]        d0_reg;
    logic [NW-1:0]         num_reg;
    logic [NW-1:0]         quo_reg;
    logic [STAMP_W-1:0]    drem_reg;
    logic                  out_valid_reg;
    logic [3:0]            gesture_reg;

    logic                  mode;
    logic [C-1:0]          lx;
    logic [C-1:0]          ly;
    logic [PTW-1:0]        pa;
    logic [PTW-1:0]        pb;
    logic [STAMP_W-1:0]    dt_raw;
    logic signed [SQW-1:0] px;
    logic signed [SQW-1:0] py;
    logic [RMW+1:0]        rem_try;
    logic [RMW+1:0]        trial;
    logic                  sq_ge;
    logic [RTW-1:0]        root_next;
    logic [STAMP_W:0]      dr_try;
    logic                  dv_ge;
    logic                  emit;

    logic signed [DW-1:0]  ax;
    logic signed [DW-1:0]  ay;
    logic                  lng;
    logic [RTW-1:0]        delta;
    logic [26:0]           nav_prod;
    logic signed [17:0]    nav;
    logic signed [17:0]    sx;
    logic signed [17:0]    sy;
    logic signed [17:0]    toc;
    logic                  has;
    logic [3:0]            code;

    assign mode = job_reg[JW-1];
    assign lx   = job_reg[JW-2 -: C];
    assign ly   = job_reg[JW-2-C -: C];
    assign pa   = pass_reg ? job_reg[2*PTW-1 -: PTW] : job_reg[4*PTW-1 -: PTW];
    assign pb   = pass_reg ? job_reg[PTW-1 -: PTW]   : job_reg[3*PTW-1 -: PTW];
    assign dt_raw = pb[STAMP_W-1:0] - pa[STAMP_W-1:0];

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;

    // one root bit per cycle
    assign rem_try   = {rem_reg, rad_reg[SQW-1 -: 2]};
    assign trial     = (RMW + 2)'({root_reg, 2'b01});
    assign sq_ge     = (rem_try >= trial);
    assign root_next = {root_reg[RTW-2:0], sq_ge};

    // one quotient bit per cycle
    assign dr_try = {drem_reg, num_reg[NW-1]};
    assign dv_ge  = (dr_try >= {1'b0, dt_reg});

    assign job_pop = (st_reg == S_IDLE) && job_valid;
    assign empty   = !out_valid_reg;
    assign gesture = gesture_reg;
    assign emit    = (st_reg == S_DECIDE) && has && (!out_valid_reg || pop);

    always_comb
    begin
        ax       = dx_reg[DW-1] ? -dx_reg : dx_reg;
        ay       = dy_reg[DW-1] ? -dy_reg : dy_reg;
        lng      = XW'(root_reg) > XW'(cfg.long_len);
        delta    = (root_reg >= d0_reg) ? root_reg - d0_reg : d0_reg - root_reg;
        nav_prod = 27'(cfg.view_w) * 27'(THIRD_RECIP);
        nav      = 18'(nav_prod >> THIRD_SHIFT);
        sx       = 18'(lx);
        sy       = 18'(ly);
        toc      = 18'(cfg.view_h) - 18'(TOC_SIZE);
        has      = 1'b0;
        code     = GEST_TAP_LEFT;
        if (mode == MODE_ONE)
        begin
            if (XW'(root_reg) < XW'(cfg.jitter))
            begin
                if (sy > 18'(TAP_MARGIN) && sx > 18'(TAP_MARGIN))
                begin
                    if (sx < nav)
                    begin
                        // lower-left corner stays quiet
                        has  = !(sy > toc && sx < 18'(TOC_SIZE));
                        code = GEST_TAP_LEFT;
                    end
                    else if (sx > (nav <<< 1))
                    begin
                        has  = 1'b1;
                        code = GEST_TAP_RIGHT;
                    end
                end
            end
            else if (VW'(quo_reg) >= VW'(cfg.min_speed))
            begin
                has = 1'b1;
                if (ax > ay)
                begin
                    code = (dx_reg > 0) ? GEST_SWIPE_RIGHT : GEST_SWIPE_LEFT;
                end
                else if (dy_reg > 0)
                begin
                    code = lng ? GEST_DOWN_LONG : GEST_DOWN;
                end
                else
                begin
                    code = lng ? GEST_UP_LONG : GEST_UP;
                end
            end
        end
        else
        begin
            has  = (XW'(root_reg) > XW'(cfg.pair_gap)) &&
                   (XW'(delta) < XW'(cfg.jitter));
            code = GEST_TWO_TAP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            pass_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            gesture_reg   <= GEST_TAP_LEFT;
            job_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dt_reg        <= '0;
            sq_reg        <= '0;
            rad_reg       <= '0;
            root_reg      <= '0;
            rem_reg       <= '0;
            d0_reg        <= '0;
            num_reg       <= '0;
            quo_reg       <= '0;
            drem_reg      <= '0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg  <= job_data;
                        pass_reg <= 1'b0;
                        st_reg   <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    dx_reg <= $signed({1'b0, pb[PTW-1 -: C]}) - $signed({1'b0, pa[PTW-1 -: C]});
                    dy_reg <= $signed({1'b0, pb[PTW-1-C -: C]})
                              - $signed({1'b0, pa[PTW-1-C -: C]});
                    dt_reg <= (dt_raw == '0) ? STAMP_W'(1) : dt_raw;
                    st_reg <= S_MULX;
                end
                S_MULX:
                begin
                    sq_reg <= px;
                    st_reg <= S_MULY;
                end
                S_MULY:
                begin
                    rad_reg  <= sq_reg + py;
                    root_reg <= '0;
                    rem_reg  <= '0;
                    cnt_reg  <= '0;
                    st_reg   <= S_SQRT;
                end
                S_SQRT:
                begin
                    rem_reg  <= sq_ge ? RMW'(rem_try - trial) : RMW'(rem_try);
                    root_reg <= root_next;
                    rad_reg  <= rad_reg << 2;
                    if (cnt_reg == CW'(NIT - 1))
                    begin
                        cnt_reg <= '0;
                        if (mode == MODE_ONE)
                        begin
                            num_reg  <= NW'(root_next) * NW'(VEL_SCALE);
                            quo_reg  <= '0;
                            drem_reg <= '0;
                            st_reg   <= S_DIV;
                        end
                        else if (!pass_reg)
                        begin
                            d0_reg   <= root_next;
                            pass_reg <= 1'b1;
                            st_reg   <= S_LOAD;
                        end
                        else
                        begin
                            st_reg <= S_DECIDE;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_DIV:
                begin
                    drem_reg <= dv_ge ? STAMP_W'(dr_try - {1'b0, dt_reg})
                                      : dr_try[STAMP_W-1:0];
                    quo_reg  <= {quo_reg[NW-2:0], dv_ge};
                    num_reg  <= num_reg << 1;
                    if (cnt_reg == CW'(NW - 1))
                    begin
                        cnt_reg <= '0;
                        st_reg  <= S_DECIDE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                S_DECIDE:
                begin
                    if (!has)
                    begin
                        st_reg <= S_IDLE;
                    end
                    else if (emit)
                    begin
                        gesture_reg <= code;
                        st_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TGC_CHECK_NOW(a_div_rem, st_reg == S_DIV, drem_reg < dt_reg, "divider remainder out of range")
    `TGC_CHECK_NEXT(a_job_load, job_pop, st_reg == S_LOAD, "taken job did not start")
    `TGC_CHECK_NOW(a_out_src, $rose(out_valid_reg), $past(st_reg) == S_DECIDE, "stray result word")

endmodule

FILE: hdl/touch_gesture_classifier.sv
// channel   direction  handshake                   payload
// events    in         push / full                 action, slot, pos_x, pos_y, stamp
// gestures  out        empty / pop                 gesture
// config    in         psel, penable, pwrite ...   pwdata / prdata, paddr
//
// Events are taken one per cycle while the two-entry job queue has room.
// A classification runs on a shared square-root / divide unit, one bit per cycle:
// one stroke runs load, square dx, add dy squared, square root, divide, decide;
// two strokes run load, squares and square root for each stroke in turn, then decide.
// rst_n clears counts, slot stores, queues and config to reset values.
// A held result stalls the back end, a full job queue stalls event input.
module touch_gesture_classifier
    import tgc_pkg::*;
#(
    parameter int SLOT_LIMIT = SLOT_LIMIT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            action,
    input  logic [3:0]            slot,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [STAMP_W-1:0]    stamp,
    output logic                  empty,
    input  logic                  pop,
    output logic [3:0]            gesture,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    localparam int PTW = 2 * COORD_BITS + STAMP_W;
    localparam int JW  = 1 + 2 * COORD_BITS + 4 * PTW;

    cfg_t          cfg_reg;
    reg_idx_t      ridx;
    logic          wr_en;
    logic          job_push;
    logic [JW-1:0] job_in;
    logic          job_full;
    logic          job_pop;
    logic [JW-1:0] job_out;
    logic          job_valid;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign full   = job_full;

    always_comb
    begin
        case (ridx)
            REG_JITTER:   prdata = DATA_W'(cfg_reg.jitter);
            REG_WIDTH:    prdata = DATA_W'(cfg_reg.view_w);
            REG_HEIGHT:   prdata = DATA_W'(cfg_reg.view_h);
            REG_VELOCITY: prdata = DATA_W'(cfg_reg.min_speed);
            REG_LONG:     prdata = DATA_W'(cfg_reg.long_len);
            REG_TWOTAP:   prdata = DATA_W'(cfg_reg.pair_gap);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (ridx)
                REG_JITTER:   cfg_reg.jitter    <= pwdata[CFG_W-1:0];
                REG_WIDTH:    cfg_reg.view_w    <= pwdata[CFG_W-1:0];
                REG_HEIGHT:   cfg_reg.view_h    <= pwdata[CFG_W-1:0];
                REG_VELOCITY: cfg_reg.min_speed <= pwdata[VEL_W-1:0];
                REG_LONG:     cfg_reg.long_len  <= pwdata[CFG_W-1:0];
                REG_TWOTAP:   cfg_reg.pair_gap  <= pwdata[CFG_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    tgc_front #(
        .SLOT_LIMIT (SLOT_LIMIT),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .action   (action),
        .slot     (slot),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .stamp    (stamp),
        .job_full (job_full),
        .job_push (job_push),
        .job_data (job_in)
    );

    tgc_queue #(
        .WIDTH (JW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_push),
        .din   (job_in),
        .full  (job_full),
        .rd    (job_pop),
        .dout  (job_out),
        .valid (job_valid)
    );

    tgc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_data  (job_out),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .gesture   (gesture)
    );

endmodule
